[rtl/upbt_pkg.sv]
// Types and constants shared by the UDP port binding table modules.
package upbt_pkg;

    localparam int DEF_ENTRIES = 16;
    localparam int SLOT_W      = 4;

    localparam logic [1:0] KIND_BIND   = 2'd0;
    localparam logic [1:0] KIND_UNBIND = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_NONE = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] port;
        logic [31:0] address;
        logic [15:0] handle;
    } upbt_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       handle_out;
    } upbt_out_t;

    // Search state handed from cell to cell along the chain.
    typedef struct packed {
        logic              active;
        logic              port_hit;
        logic [SLOT_W-1:0] port_slot;
        logic              free_hit;
        logic [SLOT_W-1:0] free_slot;
        logic              look_hit;
        logic [SLOT_W-1:0] look_slot;
        logic [15:0]       look_handle;
    } srch_t;

    // Write-back strobes broadcast to all cells.
    typedef struct packed {
        logic bind_port;
        logic bind_free;
        logic unbind;
    } cmt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

endpackage

[rtl/upbt_cell.sv]
// One binding entry plus its stage of the search chain.
module upbt_cell #(
    parameter int INDEX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  upbt_pkg::upbt_in_t query,
    input  upbt_pkg::srch_t  chain_in,
    output upbt_pkg::srch_t  chain_out,
    input  upbt_pkg::cmt_t   commit
);
    import upbt_pkg::*;

    // Reported slot is the entry index modulo 16.
    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

    logic        valid_reg, valid_next;
    logic        pclaim_reg, pclaim_next;
    logic        fclaim_reg, fclaim_next;
    logic [15:0] port_reg, port_next;
    logic [31:0] addr_reg, addr_next;
    logic [15:0] handle_reg, handle_next;
    srch_t       link_reg, link_next;

    logic port_match;
    logic free_match;
    logic look_match;
    logic wr_en;
    logic clr_en;

    assign port_match = valid_reg && (port_reg == query.port);
    assign free_match = !valid_reg;
    assign look_match = port_match && ((addr_reg == 32'd0) || (addr_reg == query.address));

    // Claims record whether this cell is the first hit of the current search.
    assign wr_en  = (commit.bind_port && pclaim_reg) || (commit.bind_free && fclaim_reg);
    assign clr_en = commit.unbind && pclaim_reg;

    always_comb
    begin
        link_next        = link_reg;
        link_next.active = chain_in.active;
        pclaim_next      = pclaim_reg;
        fclaim_next      = fclaim_reg;
        if (chain_in.active)
        begin
            link_next   = chain_in;
            pclaim_next = port_match && !chain_in.port_hit;
            fclaim_next = free_match && !chain_in.free_hit;
            if (!chain_in.port_hit && port_match)
            begin
                link_next.port_hit  = 1'b1;
                link_next.port_slot = MY_SLOT;
            end
            if (!chain_in.free_hit && free_match)
            begin
                link_next.free_hit  = 1'b1;
                link_next.free_slot = MY_SLOT;
            end
            if (!chain_in.look_hit && look_match)
            begin
                link_next.look_hit    = 1'b1;
                link_next.look_slot   = MY_SLOT;
                link_next.look_handle = handle_reg;
            end
        end
    end

    always_comb
    begin
        valid_next  = valid_reg;
        port_next   = port_reg;
        addr_next   = addr_reg;
        handle_next = handle_reg;
        if (wr_en)
        begin
            valid_next  = 1'b1;
            port_next   = query.port;
            addr_next   = query.address;
            handle_next = query.handle;
        end
        else if (clr_en)
        begin
            valid_next  = 1'b0;
            handle_next = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            pclaim_reg <= 1'b0;
            fclaim_reg <= 1'b0;
            link_reg   <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            pclaim_reg <= pclaim_next;
            fclaim_reg <= fclaim_next;
            link_reg   <= link_next;
        end
    end

    always_ff @(posedge clk)
    begin
        port_reg   <= port_next;
        addr_reg   <= addr_next;
        handle_reg <= handle_next;
    end

    assign chain_out = link_reg;

endmodule

[rtl/udp_port_binding_table.sv]
// UDP port binding table: ENTRIES cells searched by a token passed along the chain.
// The request is registered at the accepting edge; the search state then walks the
// chain through the link register of each cell (first port match, first free entry
// and first lookup hit are carried along in priority order), the result is decided
// from the tail, and the chosen entry is written at the edge that loads the result.
// One transaction is in the table at a time; a new one is accepted as soon as the
// previous result is loaded, even while it is still waiting for out_ready, and a
// result that is not taken holds the next one in the decide state. Valid marks
// clear at reset and no clearing pass is needed.
module udp_port_binding_table #(
    parameter int ENTRIES = upbt_pkg::DEF_ENTRIES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  upbt_pkg::upbt_in_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output upbt_pkg::upbt_out_t out_data
);
    import upbt_pkg::*;

    state_t    state_reg, state_next;
    logic      start_reg, start_next;
    upbt_in_t  query_reg;
    logic      out_valid_reg, out_valid_next;
    upbt_out_t out_data_reg;
    upbt_out_t result;
    cmt_t      commit;
    logic      accept;
    logic      out_load;

    srch_t          head;
    srch_t          chain [ENTRIES+1];
    srch_t          tail;
    logic [ENTRIES:0] act_vec;

    assign accept = in_valid && in_ready;
    assign tail   = chain[ENTRIES];

    always_comb
    begin
        head        = '0;
        head.active = start_reg;
    end

    assign chain[0]   = head;
    assign act_vec[0] = start_reg;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        upbt_cell #(
            .INDEX(i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .query     (query_reg),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .commit    (commit)
        );
        assign act_vec[i+1] = chain[i+1].active;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (tail.active)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb
    begin
        in_ready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_SEARCH: in_ready = 1'b0;
            ST_DONE:   out_load = !out_valid_reg || out_ready;
            default:   in_ready = 1'b0;
        endcase
    end

    // Decision from the tail of the chain; fields hold after the token passes.
    always_comb
    begin
        result = '{status: STAT_NONE, slot: '0, handle_out: 16'd0};
        commit = '0;
        case (query_reg.kind)
            KIND_BIND:
            begin
                if (tail.port_hit)
                begin
                    result.status    = STAT_DONE;
                    result.slot      = tail.port_slot;
                    commit.bind_port = out_load;
                end
                else if (tail.free_hit)
                begin
                    result.status    = STAT_DONE;
                    result.slot      = tail.free_slot;
                    commit.bind_free = out_load;
                end
                else
                    result.status = STAT_FULL;
            end
            KIND_UNBIND:
            begin
                if (tail.port_hit)
                begin
                    result.status = STAT_DONE;
                    result.slot   = tail.port_slot;
                    commit.unbind = out_load;
                end
            end
            KIND_LOOKUP:
            begin
                if (tail.look_hit)
                begin
                    result.status     = STAT_DONE;
                    result.slot       = tail.look_slot;
                    result.handle_out = tail.look_handle;
                end
            end
            default: result.status = STAT_NONE;
        endcase
    end

    assign start_next = accept;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            query_reg <= in_data;
        if (out_load)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Only one search token may be on the chain.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(act_vec))
        else $error("more than one search token on the chain");

    // Table writes happen only when the result is loaded.
    a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (commit.bind_port || commit.bind_free || commit.unbind) |->
            (state_reg == ST_DONE && out_load))
        else $error("table write outside result load");

    // A failed transaction reports slot 0 and handle 0.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status != STAT_DONE) |->
            (out_data_reg.slot == '0 && out_data_reg.handle_out == 16'd0))
        else $error("failed transaction carries slot or handle");

    // The token leaves the chain only while a search is pending.
    a_tail_search: assert property (@(posedge clk) disable iff (!rst_n)
        tail.active |-> state_reg == ST_SEARCH)
        else $error("search token arrived outside search state");

    // An accepted transaction starts the chain on the next cycle.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (start_reg && state_reg == ST_SEARCH))
        else $error("accepted transaction did not start a search");

endmodule
